// File: sv/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants and types for the circular double-ended queue unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int unsigned CDQ_CAPACITY = 16;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned FUNC_W       = 3;

	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;

	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
		logic clear;
	} cdq_ctrl_t;

endpackage

// File: sv/cdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_cell
// One slot of the queue row: holds one entry and its occupancy bit, and
// shifts toward either neighbor as the front of the queue moves.
// ----------------------------------------------------------------------------
module cdq_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cdq_pkg::cdq_ctrl_t              ctrl,
	input  logic signed [cdq_pkg::DATA_W-1:0] push_value,
	input  logic signed [cdq_pkg::DATA_W-1:0] prev_data,
	input  logic                            prev_valid,
	input  logic signed [cdq_pkg::DATA_W-1:0] next_data,
	input  logic                            next_valid,
	output logic signed [cdq_pkg::DATA_W-1:0] data,
	output logic                            valid,
	output logic                            tail
);
	import cdq_pkg::*;

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;
	logic                     valid_q;
	logic                     valid_d;

	always_comb begin
		data_d  = data_q;
		valid_d = valid_q;
		if (ctrl.clear) begin
			valid_d = 1'b0;
		end else if (ctrl.push_front) begin
			data_d  = prev_data;
			valid_d = prev_valid;
		end else if (ctrl.push_back) begin
			if (!valid_q && prev_valid) begin
				data_d  = push_value;
				valid_d = 1'b1;
			end
		end else if (ctrl.pop_front) begin
			data_d  = next_data;
			valid_d = next_valid;
		end else if (ctrl.pop_back) begin
			if (valid_q && !next_valid) begin
				valid_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data  = data_q;
	assign valid = valid_q;
	assign tail  = valid_q && !next_valid;

endmodule

// File: sv/circular_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_double_ended_queue_unit
// Double-ended queue of signed 32-bit entries built as a row of shifting
// cells; the front entry always sits in cell 0.
//
//   channel   handshake        fields
//   request   start / busy     func, push_value
//   result    done (strobe)    accepted, popped_value, is_empty, is_full
//
// One request per cycle; its result appears on the cycle after acceptance.
// busy is never raised: every cell updates in the cycle of the request.
// Reset empties every cell at once; no clearing pass.
// The receiver cannot stall; results are shown for exactly one cycle.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_unit #(
	parameter int unsigned CAPACITY = cdq_pkg::CDQ_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [cdq_pkg::FUNC_W-1:0]        func,
	input  logic signed [cdq_pkg::DATA_W-1:0] push_value,
	output logic                              done,
	output logic                              accepted,
	output logic signed [cdq_pkg::DATA_W-1:0] popped_value,
	output logic                              is_empty,
	output logic                              is_full
);
	import cdq_pkg::*;

	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	logic                     cell_valid [CAPACITY];
	logic                     cell_tail [CAPACITY];
	logic signed [DATA_W-1:0] back_data;
	logic                     full;
	logic                     empty;
	logic                     take;
	cdq_ctrl_t                ctrl;
	logic signed [DATA_W-1:0] popped_d;
	logic                     done_q;
	logic                     accepted_q;
	logic signed [DATA_W-1:0] popped_q;

	assign busy  = 1'b0;
	assign take  = start && !busy;
	assign full  = cell_valid[CAPACITY-1];
	assign empty = !cell_valid[0];

	always_comb begin
		ctrl.push_front = take && (func == FUNC_PUSH_FRONT) && !full;
		ctrl.push_back  = take && (func == FUNC_PUSH_BACK) && !full;
		ctrl.pop_front  = take && (func == FUNC_POP_FRONT) && !empty;
		ctrl.pop_back   = take && (func == FUNC_POP_BACK) && !empty;
		ctrl.clear      = take && (func == FUNC_CLEAR);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] prev_data;
		logic                     prev_valid;
		logic signed [DATA_W-1:0] next_data;
		logic                     next_valid;

		if (i == 0) begin : g_first
			assign prev_data  = push_value;
			assign prev_valid = 1'b1;
		end else begin : g_mid_prev
			assign prev_data  = cell_data[i-1];
			assign prev_valid = cell_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_data  = '0;
			assign next_valid = 1'b0;
		end else begin : g_mid_next
			assign next_data  = cell_data[i+1];
			assign next_valid = cell_valid[i+1];
		end

		cdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.push_value (push_value),
			.prev_data  (prev_data),
			.prev_valid (prev_valid),
			.next_data  (next_data),
			.next_valid (next_valid),
			.data       (cell_data[i]),
			.valid      (cell_valid[i]),
			.tail       (cell_tail[i])
		);
	end

	// select the back entry: at most one cell flags itself as the tail (none when empty)
	always_comb begin
		back_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_tail[i]) begin
				back_data = back_data | cell_data[i];
			end
		end
	end

	always_comb begin
		popped_d = '0;
		if (ctrl.pop_front) begin
			popped_d = cell_data[0];
		end else if (ctrl.pop_back) begin
			popped_d = back_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			accepted_q <= 1'b0;
		end else begin
			done_q     <= take;
			accepted_q <= ctrl.push_front || ctrl.push_back || ctrl.pop_front
				|| ctrl.pop_back || ctrl.clear;
		end
	end

	always_ff @(posedge clk) begin
		popped_q <= popped_d;
	end

	assign done         = done_q;
	assign accepted     = accepted_q;
	assign popped_value = popped_q;
	assign is_empty     = empty;
	assign is_full      = full;

endmodule

// File: sv/cdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the queue unit: result timing, refusals and flags.
// ----------------------------------------------------------------------------
module cdq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic [cdq_pkg::FUNC_W-1:0]        func,
	input logic                              done,
	input logic                              accepted,
	input logic signed [cdq_pkg::DATA_W-1:0] popped_value,
	input logic                              is_empty,
	input logic                              is_full
);
	import cdq_pkg::*;

	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy))
		else $error("result strobe does not match the accepted request");

	a_refused_pops_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !accepted) |-> (popped_value == '0))
		else $error("refused request returned a nonzero value");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(is_empty && is_full))
		else $error("queue flagged both empty and full");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_CLEAR) |=> (done && accepted && is_empty))
		else $error("clear did not leave the queue empty");

	a_push_refused_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FUNC_PUSH_FRONT || func == FUNC_PUSH_BACK))
		|=> (accepted ? !is_empty : is_full))
		else $error("push result disagrees with the full flag");

endmodule

bind circular_double_ended_queue_unit cdq_checker u_cdq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.func         (func),
	.done         (done),
	.accepted     (accepted),
	.popped_value (popped_value),
	.is_empty     (is_empty),
	.is_full      (is_full)
);

// File: test/circular_double_ended_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_double_ended_queue_unit_tb
// Self-checking bench for the circular double-ended queue unit. A table of
// directed requests covers the empty and full corners, value extremes,
// clear and the unused operation codes. Random bursts that lean toward
// filling or draining then follow. Every accepted request runs through a
// shadow deque, and each done strobe is compared field by field with the
// oldest predicted outcome. Sender gaps vary by phase.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_unit_tb;

	import cdq_pkg::*;

	localparam int unsigned CAP           = CDQ_CAPACITY;
	localparam int unsigned STALL_LIMIT   = 1000;
	localparam int unsigned PHASE_ITEMS   = 634;

	localparam logic [FUNC_W-1:0] FUNC_RSVD_5 = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic                     accepted;
		logic signed [DATA_W-1:0] popped_value;
		logic                     is_empty;
		logic                     is_full;
	} outcome_t;

	typedef struct packed {
		logic [FUNC_W-1:0]        op;
		logic signed [DATA_W-1:0] value;
		logic                     fixed;
		outcome_t                 outcome;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [FUNC_W-1:0]        func = '0;
	logic signed [DATA_W-1:0] push_value = '0;
	logic                     busy;
	logic                     done;
	logic                     accepted;
	logic signed [DATA_W-1:0] popped_value;
	logic                     is_empty;
	logic                     is_full;

	logic     row_fixed = 1'b0;
	outcome_t row_outcome = '0;

	logic signed [DATA_W-1:0] shadow_store [CAP];
	int unsigned              shadow_head = 0;
	int unsigned              shadow_tail = CAP - 1;
	int unsigned              shadow_count = 0;

	outcome_t    pending_outcomes [$];
	stim_row_t   directed_rows [$];
	int unsigned idle_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	always #1 clk = ~clk;

	circular_double_ended_queue_unit #(
		.CAPACITY(CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.push_value(push_value),
		.done(done),
		.accepted(accepted),
		.popped_value(popped_value),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	function automatic outcome_t deque_apply(logic [FUNC_W-1:0] op,
			logic signed [DATA_W-1:0] value);
		outcome_t res;
		res = '0;
		case (op)
		FUNC_PUSH_FRONT: if (shadow_count < CAP) begin
			shadow_head = (shadow_head + CAP - 1) % CAP;
			shadow_store[shadow_head] = value;
			shadow_count++;
			res.accepted = 1'b1;
		end
		FUNC_PUSH_BACK: if (shadow_count < CAP) begin
			shadow_tail = (shadow_tail + 1) % CAP;
			shadow_store[shadow_tail] = value;
			shadow_count++;
			res.accepted = 1'b1;
		end
		FUNC_POP_FRONT: if (shadow_count != 0) begin
			res.popped_value = shadow_store[shadow_head];
			shadow_head = (shadow_head + 1) % CAP;
			shadow_count--;
			res.accepted = 1'b1;
		end
		FUNC_POP_BACK: if (shadow_count != 0) begin
			res.popped_value = shadow_store[shadow_tail];
			shadow_tail = (shadow_tail + CAP - 1) % CAP;
			shadow_count--;
			res.accepted = 1'b1;
		end
		FUNC_CLEAR: begin
			shadow_head = 0;
			shadow_tail = CAP - 1;
			shadow_count = 0;
			res.accepted = 1'b1;
		end
		default: ;
		endcase
		res.is_empty = (shadow_count == 0);
		res.is_full = (shadow_count == CAP);
		return res;
	endfunction

	function automatic logic signed [DATA_W-1:0] draw_value();
		case ($urandom_range(15))
		0: return VAL_MIN;
		1: return VAL_MAX;
		2: return '0;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [FUNC_W-1:0] draw_func(int unsigned push_pct);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 1) return FUNC_CLEAR;
		if (roll < 3) begin
			case ($urandom_range(2))
			0: return FUNC_RSVD_5;
			1: return FUNC_RSVD_6;
			default: return FUNC_RSVD_7;
			endcase
		end
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
		return $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
	endfunction

	task automatic add_row(logic [FUNC_W-1:0] op, logic signed [DATA_W-1:0] value,
			logic fixed, outcome_t outcome);
		stim_row_t row;
		row.op = op;
		row.value = value;
		row.fixed = fixed;
		row.outcome = outcome;
		directed_rows.push_back(row);
	endtask

	task automatic send_request(logic [FUNC_W-1:0] op, logic signed [DATA_W-1:0] value,
			logic fixed, outcome_t outcome);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= op;
		push_value <= value;
		row_fixed <= fixed;
		row_outcome <= outcome;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// predict on acceptance, then check any result shown this cycle
	always @(posedge clk) begin
		outcome_t predicted;
		outcome_t want;
		if (arst_n) begin
			if (start && !busy) begin
				predicted = deque_apply(func, push_value);
				pending_outcomes.push_back(row_fixed ? row_outcome : predicted);
			end
			if (done) begin
				if (pending_outcomes.size() == 0) begin
					$error("result with no request pending");
					mismatch_count++;
				end else begin
					want = pending_outcomes.pop_front();
					if (accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, accepted);
						mismatch_count++;
					end
					if (popped_value !== want.popped_value) begin
						$error("popped_value: expected %0d, got %0d",
							want.popped_value, popped_value);
						mismatch_count++;
					end
					if (is_empty !== want.is_empty) begin
						$error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
						mismatch_count++;
					end
					if (is_full !== want.is_full) begin
						$error("is_full: expected %0d, got %0d", want.is_full, is_full);
						mismatch_count++;
					end
				end
			end
			if ((start && !busy) || done) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$error("no progress for %0d cycles", STALL_LIMIT);
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	initial begin
		int unsigned phase;
		int unsigned sent;
		int unsigned tilt;
		int unsigned burst;
		logic [FUNC_W-1:0] op;
		logic signed [DATA_W-1:0] fill_value;

		add_row(FUNC_POP_FRONT, 32'sd7, 1'b1, '{1'b0, '0, 1'b1, 1'b0});
		add_row(FUNC_POP_BACK, VAL_MIN, 1'b1, '{1'b0, '0, 1'b1, 1'b0});
		add_row(FUNC_RSVD_5, VAL_MAX, 1'b1, '{1'b0, '0, 1'b1, 1'b0});
		add_row(FUNC_CLEAR, '1, 1'b1, '{1'b1, '0, 1'b1, 1'b0});
		for (int i = 0; i < CAP; i++) begin
			case (i % 6)
			0: fill_value = VAL_MIN;
			1: fill_value = VAL_MAX;
			2: fill_value = '1;
			3: fill_value = 32'sh5555_5555;
			4: fill_value = 32'shaaaa_aaaa;
			default: fill_value = i;
			endcase
			add_row(i[0] ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, fill_value, 1'b0, '0);
		end
		add_row(FUNC_PUSH_FRONT, 32'sd1, 1'b1, '{1'b0, '0, 1'b0, 1'b1});
		add_row(FUNC_PUSH_BACK, 32'sd2, 1'b1, '{1'b0, '0, 1'b0, 1'b1});
		add_row(FUNC_RSVD_6, 32'sd3, 1'b1, '{1'b0, '0, 1'b0, 1'b1});
		add_row(FUNC_POP_FRONT, '0, 1'b0, '0);
		add_row(FUNC_POP_BACK, '0, 1'b0, '0);
		add_row(FUNC_CLEAR, '0, 1'b1, '{1'b1, '0, 1'b1, 1'b0});
		add_row(FUNC_RSVD_7, '1, 1'b1, '{1'b0, '0, 1'b1, 1'b0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
			0: idle_pct = 18;
			1: idle_pct = 85;
			default: idle_pct = 0;
			endcase
			if (phase == 0) begin
				foreach (directed_rows[i])
					send_request(directed_rows[i].op, directed_rows[i].value,
						directed_rows[i].fixed, directed_rows[i].outcome);
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				case ($urandom_range(2))
				0: tilt = 85;
				1: tilt = 15;
				default: tilt = 50;
				endcase
				burst = $urandom_range(40, 4);
				repeat (burst) begin
					op = draw_func(tilt);
					send_request(op, draw_value(), 1'b0, '0);
					if (op <= FUNC_CLEAR) sent++;
				end
			end
		end

		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
